// ===== rtl/core/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types and codes for the position history cursor.
// ----------------------------------------------------------------------------
`default_nettype none
package phc_pkg;

   typedef enum logic [2:0] {
      FN_RECORD = 3'd0,
      FN_BACK   = 3'd1,
      FN_FWD    = 3'd2,
      FN_CLOSE  = 3'd3,
      FN_SHOW   = 3'd4
   } func_type;

   typedef struct packed {
      logic [7:0]  page;
      logic [19:0] line;
      logic [15:0] offset;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RD   = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_RSP  = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/core/phc_store.sv =====
// ----------------------------------------------------------------------------
// phc_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module phc_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire phc_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output phc_pkg::entry_type      rd_data
);
   import phc_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/position_history_cursor.sv =====
// ----------------------------------------------------------------------------
// position_history_cursor
// Back/forward history of (page, line, offset) positions with a cursor.
// ----------------------------------------------------------------------------
// Record writes, after reading the current entry unless the history is empty;
// back, forward and show read, then register the response. Page closed walks
// the live entries through the one read port. One beat is in work at a time.
// Reset (synchronous) empties the history; memory contents are not cleared.
`default_nettype none
module position_history_cursor #(
   parameter int HISTORY_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_page_tag,
   input  wire logic [19:0] req_line_number,
   input  wire logic [15:0] req_column_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_page,
   output logic [19:0]      rsp_out_line,
   output logic [15:0]      rsp_out_offset
);
   import phc_pkg::*;

   localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);

   function automatic logic [IW-1:0] phys(input logic [IW-1:0] b, input logic [CW-1:0] i);
      logic [CW:0] s;
      s = (CW+1)'(b) + (CW+1)'(i);
      if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
      return s[IW-1:0];
   endfunction

   state_type       state_ff, state_in;
   func_type        func_ff, func_in;
   entry_type       req_ff, req_in;
   entry_type       hold_ff, hold_in;
   entry_type       rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   cur_ff, cur_in;
   logic [IW-1:0]   base_ff, base_in;
   logic [CW-1:0]   scan_ff, scan_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            vld_ff, vld_in;
   logic [CW-1:0]   keep_ff, keep_in;
   logic [CW-1:0]   bef_ff, bef_in;
   logic            later_ff, later_in;

   logic            wr_en, rd_en;
   logic [IW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_data;
   entry_type       req_entry;
   logic [CW-1:0]   nxt;
   logic [IW-1:0]   nbase;
   logic            accept;

   phc_store #(.DEPTH(HISTORY_DEPTH), .AW(IW)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_entry = '{page: req_page_tag, line: req_line_number, offset: req_column_offset};

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      req_in       = req_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      count_in     = count_ff;
      cur_in       = cur_ff;
      base_in      = base_ff;
      scan_in      = scan_ff;
      idx_in       = idx_ff;
      vld_in       = 1'b0;
      keep_in      = keep_ff;
      bef_in       = bef_ff;
      later_in     = later_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = req_ff;
      rd_en        = 1'b0;
      rd_addr      = phys(base_ff, CW'(cur_ff));
      nxt          = CW'(cur_ff) + CW'(1);
      nbase        = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = func_type'(req_func);
               req_in  = req_entry;
               unique case (req_func)
                  FN_RECORD: begin
                     if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = phys(base_ff, '0);
                        wr_data  = req_entry;
                        cur_in   = '0;
                        count_in = CW'(1);
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_RD;
                     end
                  end
                  FN_BACK: begin
                     if (count_ff != '0 && cur_ff != '0) begin
                        cur_in   = cur_ff - IW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = phys(base_ff, CW'(cur_ff - IW'(1)));
                        state_in = ST_RD;
                     end
                  end
                  FN_FWD: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = ST_RD;
                        if (nxt < count_ff) begin
                           cur_in  = nxt[IW-1:0];
                           rd_addr = phys(base_ff, nxt);
                        end
                     end
                  end
                  FN_SHOW: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = ST_RD;
                     end
                  end
                  FN_CLOSE: begin
                     if (count_ff != '0) begin
                        scan_in  = '0;
                        keep_in  = '0;
                        bef_in   = '0;
                        later_in = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            if (func_ff == FN_RECORD) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
               if (rd_data.page == req_ff.page && rd_data.line == req_ff.line) begin
                  wr_addr = phys(base_ff, CW'(cur_ff));
               end else begin
                  if (nxt == CW'(HISTORY_DEPTH)) begin
                     nbase = phys(base_ff, CW'(1));
                     nxt   = CW'(HISTORY_DEPTH - 1);
                  end
                  base_in  = nbase;
                  wr_addr  = phys(nbase, nxt);
                  cur_in   = nxt[IW-1:0];
                  count_in = nxt + CW'(1);
               end
            end else begin
               hold_in  = rd_data;
               state_in = ST_RSP;
            end
         end
         ST_SCAN: begin
            if (vld_ff && rd_data.page != req_ff.page) begin
               wr_en   = 1'b1;
               wr_addr = phys(base_ff, keep_ff);
               wr_data = rd_data;
               keep_in = keep_ff + CW'(1);
               if (idx_ff < CW'(cur_ff)) bef_in = bef_ff + CW'(1);
               else later_in = 1'b1;
            end
            if (scan_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = phys(base_ff, scan_ff);
               idx_in  = scan_ff;
               vld_in  = 1'b1;
               scan_in = scan_ff + CW'(1);
            end else if (!vld_ff) begin
               count_in = keep_ff;
               state_in = ST_IDLE;
               if (keep_ff == '0) cur_in = '0;
               else if (later_ff) cur_in = bef_ff[IW-1:0];
               else cur_in = IW'(keep_ff - CW'(1));
            end
         end
         ST_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         cur_ff       <= '0;
         base_ff      <= '0;
         vld_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         base_ff      <= base_in;
         vld_ff       <= vld_in;
      end
      func_ff  <= func_in;
      req_ff   <= req_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
      scan_ff  <= scan_in;
      idx_ff   <= idx_in;
      keep_ff  <= keep_in;
      bef_ff   <= bef_in;
      later_ff <= later_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_page   = rsp_ff.page;
   assign rsp_out_line   = rsp_ff.line;
   assign rsp_out_offset = rsp_ff.offset;

endmodule
`default_nettype wire

// ===== rtl/core/phc_checker.sv =====
// ----------------------------------------------------------------------------
// phc_checker
// Port-level checks for the position history cursor.
// ----------------------------------------------------------------------------
`default_nettype none
module phc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [2:0]  req_func,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_page,
   input wire logic [19:0] rsp_out_line,
   input wire logic [15:0] rsp_out_offset
);
   import phc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_page)
         && $stable(rsp_out_line) && $stable(rsp_out_offset))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_record_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FN_RECORD || req_func == FN_CLOSE)
         |=> !$rose(rsp_valid))
      else $error("rsp beat from record or page closed");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != FN_RECORD && req_func != FN_CLOSE
         |=> !req_ready || !$rose(rsp_valid))
      else $error("ready returned with no work done");

endmodule

bind position_history_cursor phc_checker u_phc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_func      (req_func),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_page  (rsp_out_page),
   .rsp_out_line  (rsp_out_line),
   .rsp_out_offset(rsp_out_offset)
);
`default_nettype wire

// ===== dv/position_history_cursor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// position_history_cursor_tb
// Drives record, back, forward, page-closed, show and unused-code beats, with
// random gaps on both channels and one long response stall. Every response
// beat is checked against an in-bench history model, in order.
// ----------------------------------------------------------------------------
module position_history_cursor_tb;
   import phc_pkg::*;

   localparam int DEPTH = 256;
   localparam logic [2:0] FN_BAD = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_page_tag = '0;
   logic [19:0] req_line_number = '0;
   logic [15:0] req_column_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_page;
   logic [19:0] rsp_out_line;
   logic [15:0] rsp_out_offset;

   position_history_cursor #(.HISTORY_DEPTH(DEPTH)) DUT (.*);

   always #4 clock = ~clock;

   // history model: entries kept in age order
   entry_type hist_q[$];
   int        cur_idx;
   entry_type pos_due_q[$];
   int        pushed = 0;
   int        errors = 0;
   bit        stall_long = 1'b0;
   bit        sending_done = 1'b0;

   typedef struct {
      logic [2:0]  fn;
      logic [7:0]  pg;
      logic [19:0] ln;
      logic [15:0] off;
      bit          typed;
      bit          has_pos;
      entry_type   pos;
   } row_type;

   function automatic void predict_pos(input logic [2:0] fn, input entry_type e);
      entry_type kept[$];
      int before_cur;
      bit later;
      case (fn)
         FN_RECORD: begin
            if (hist_q.size() != 0 && hist_q[cur_idx].page == e.page &&
                hist_q[cur_idx].line == e.line) begin
               hist_q[cur_idx].offset = e.offset;
            end else begin
               while (hist_q.size() > cur_idx + 1) void'(hist_q.pop_back());
               if (hist_q.size() >= DEPTH) void'(hist_q.pop_front());
               hist_q.push_back(e);
               cur_idx = hist_q.size() - 1;
            end
         end
         FN_BACK: begin
            if (hist_q.size() != 0 && cur_idx != 0) begin
               cur_idx--;
               pos_due_q.push_back(hist_q[cur_idx]);
               pushed++;
            end
         end
         FN_FWD: begin
            if (hist_q.size() != 0) begin
               if (cur_idx + 1 < hist_q.size()) cur_idx++;
               pos_due_q.push_back(hist_q[cur_idx]);
               pushed++;
            end
         end
         FN_CLOSE: begin
            before_cur = 0;
            later = 0;
            foreach (hist_q[i]) begin
               if (hist_q[i].page != e.page) begin
                  kept.push_back(hist_q[i]);
                  if (i < cur_idx) before_cur++;
                  else later = 1;
               end
            end
            hist_q = kept;
            if (kept.size() == 0) cur_idx = 0;
            else if (later) cur_idx = before_cur;
            else cur_idx = kept.size() - 1;
         end
         FN_SHOW: begin
            if (hist_q.size() != 0) begin
               pos_due_q.push_back(hist_q[cur_idx]);
               pushed++;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_beat(input logic [2:0] fn, input logic [7:0] pg,
                            input logic [19:0] ln, input logic [15:0] off);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
            (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_page_tag <= pg;
      req_line_number <= ln;
      req_column_offset <= off;
      do @(posedge clock); while (!req_ready);
      predict_pos(fn, '{page: pg, line: ln, offset: off});
   endtask

   function automatic row_type mk(input logic [2:0] fn, input logic [7:0] pg,
                                  input logic [19:0] ln, input logic [15:0] off);
      row_type r;
      r.fn = fn; r.pg = pg; r.ln = ln; r.off = off;
      r.typed = 0; r.has_pos = 0; r.pos = '0;
      return r;
   endfunction

   // response side
   initial begin
      int idle;
      entry_type want;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pos_due_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat %h %h %h",
                  rsp_out_page, rsp_out_line, rsp_out_offset);
            end else begin
               want = pos_due_q.pop_front();
               if (rsp_out_page !== want.page || rsp_out_line !== want.line ||
                   rsp_out_offset !== want.offset) begin
                  errors++;
                  if (errors <= 10) $display("mismatch exp %h %h %h got %h %h %h",
                     want.page, want.line, want.offset,
                     rsp_out_page, rsp_out_line, rsp_out_offset);
               end
            end
         end
         if (stall_long) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            stall_long = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            idle = $urandom_range(0, 9);
            rsp_ready <= (idle < 2) ? 1'b0 : 1'b1;
            if (idle == 0 && !sending_done) begin
               @(posedge clock);
               if (rsp_valid && rsp_ready) begin
                  // ready is already low at this edge, so no beat is taken here
               end
               repeat ($urandom_range(5, 30)) @(posedge clock);
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      row_type rows[$];
      row_type r;
      logic [2:0] fn;
      logic [7:0] pg;
      int n;
      int k;
      int n0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty history, extremes, boundary cases
      r = mk(FN_SHOW, 8'h00, 0, 0); r.typed = 1; rows.push_back(r);
      r = mk(FN_BACK, 8'h00, 0, 0); r.typed = 1; rows.push_back(r);
      r = mk(FN_FWD, 8'h00, 0, 0); r.typed = 1; rows.push_back(r);
      rows.push_back(mk(FN_CLOSE, 8'h00, 0, 0));
      rows.push_back(mk(FN_RECORD, 8'hFF, 20'hFFFFF, 16'hFFFF));
      r = mk(FN_SHOW, 0, 0, 0); r.typed = 1; r.has_pos = 1;
      r.pos = '{8'hFF, 20'hFFFFF, 16'hFFFF}; rows.push_back(r);
      r = mk(FN_BACK, 0, 0, 0); r.typed = 1; rows.push_back(r);
      r = mk(FN_FWD, 0, 0, 0); r.typed = 1; r.has_pos = 1;
      r.pos = '{8'hFF, 20'hFFFFF, 16'hFFFF}; rows.push_back(r);
      rows.push_back(mk(FN_RECORD, 8'hFF, 20'hFFFFF, 16'h0000));
      rows.push_back(mk(FN_RECORD, 8'h00, 20'h00000, 16'h1234));
      rows.push_back(mk(FN_RECORD, 8'h5A, 20'hA5A5A, 16'h5A5A));
      rows.push_back(mk(FN_BACK, 0, 0, 0));
      rows.push_back(mk(FN_BACK, 0, 0, 0));
      rows.push_back(mk(FN_RECORD, 8'h01, 20'h00001, 16'h0001));
      rows.push_back(mk(FN_FWD, 0, 0, 0));
      rows.push_back(mk(FN_BACK, 0, 0, 0));
      rows.push_back(mk(FN_CLOSE, 8'h01, 0, 0));
      rows.push_back(mk(FN_SHOW, 0, 0, 0));
      rows.push_back(mk(FN_CLOSE, 8'hFF, 0, 0));
      rows.push_back(mk(FN_SHOW, 0, 0, 0));
      rows.push_back(mk(FN_BAD, 8'hFF, 20'hFFFFF, 16'hFFFF));
      rows.push_back(mk(3'd5, 0, 0, 0));
      rows.push_back(mk(3'd6, 0, 0, 0));
      rows.push_back(mk(FN_CLOSE, 8'h00, 0, 0));
      r = mk(FN_SHOW, 0, 0, 0); r.typed = 1; rows.push_back(r);

      foreach (rows[i]) begin
         n0 = pushed;
         send_beat(rows[i].fn, rows[i].pg, rows[i].ln, rows[i].off);
         if (rows[i].typed) begin
            // typed expectation and predicted one must agree
            if (rows[i].has_pos ? (pushed != n0 + 1 || pos_due_q[$] != rows[i].pos)
                                : (pushed != n0)) begin
               errors++;
               if (errors <= 10) $display("row %0d: model disagrees with table", i);
            end
         end
      end

      // fill past the store depth to force eviction, then walk back to the oldest
      for (k = 0; k < DEPTH + 20; k++)
         send_beat(FN_RECORD, k[7:0], 20'($urandom_range(0, 20'hFFFFF)), 16'($urandom()));
      stall_long = 1'b1;
      for (k = 0; k < DEPTH + 5; k++) send_beat(FN_BACK, 0, 0, 0);
      send_beat(FN_CLOSE, 8'd30, 0, 0);
      send_beat(FN_SHOW, 0, 0, 0);

      // random: mostly few pages so records match and closes hit
      for (n = 0; n < 1700; n++) begin
         k = $urandom_range(0, 99);
         pg = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5));
         if (k < 40) fn = FN_RECORD;
         else if (k < 58) fn = FN_BACK;
         else if (k < 74) fn = FN_FWD;
         else if (k < 80) fn = FN_CLOSE;
         else if (k < 97) fn = FN_SHOW;
         else fn = 3'($urandom_range(5, 7));
         send_beat(fn, pg,
            ($urandom_range(0, 3) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 3)),
            16'($urandom()));
      end
      req_valid <= 1'b0;

      sending_done = 1'b1;
      n = 0;
      while (pos_due_q.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (600) @(posedge clock);
      if (errors == 0 && pos_due_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/phc_pkg.sv
rtl/core/phc_store.sv
rtl/core/position_history_cursor.sv
rtl/core/phc_checker.sv
dv/position_history_cursor_tb.sv
